// File: sv/jvae_pkg.sv
`timescale 1ns / 1ps

package jvae_pkg;

    localparam int JVAE_NUM_JOINTS = 8;

    localparam int JOINT_W    = 3;
    localparam int VEL_W      = 32;
    localparam int TICK_W     = 15;
    localparam int TAU_W      = 16;
    localparam int MUL_W      = 16;
    localparam int OPD_W      = VEL_W + 1;
    localparam int ACC_W      = 49;
    localparam int DEN_W      = TAU_W + 1;
    localparam int QUO_W      = 34;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [TICK_W-1:0] TICK_WRAP_MS = 15'd32767;
    localparam logic [MUL_W-1:0]  MS_PER_S     = 16'd1000;
    localparam logic [TAU_W-1:0]  TAU_RESET    = 16'd10;

    typedef enum logic [0:0] {
        REG_VELOCITY_TAU = 1'b0,
        REG_ACCEL_TAU    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic done;
        logic saturated;
    } div_status_t;

endpackage

// File: sv/jvae_serial_mac.sv
`timescale 1ns / 1ps

module jvae_serial_mac import jvae_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [OPD_W-1:0]        op_a,
    input  logic [OPD_W-1:0]        op_b,
    input  logic [MUL_W-1:0]        mul_a,
    input  logic [MUL_W-1:0]        mul_b,
    output logic                    done,
    output logic [ACC_W-1:0]        acc
);

    localparam int CNT_W = $clog2(MUL_W);

    logic [OPD_W-1:0] a_reg;
    logic [OPD_W-1:0] b_reg;
    logic [MUL_W-1:0] ma_reg;
    logic [MUL_W-1:0] mb_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ACC_W-1:0] pp_a;
    logic [ACC_W-1:0] pp_b;
    logic             last;

    // MSB-first shift-add: one multiplier bit of each product per cycle
    always_comb begin
        pp_a     = ma_reg[MUL_W-1] ? {{(ACC_W-OPD_W){a_reg[OPD_W-1]}}, a_reg} : '0;
        pp_b     = mb_reg[MUL_W-1] ? {{(ACC_W-OPD_W){b_reg[OPD_W-1]}}, b_reg} : '0;
        acc_next = {acc_reg[ACC_W-2:0], 1'b0} + pp_a + pp_b;
        last     = (cnt_reg == CNT_W'(MUL_W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            ma_reg  <= mul_a;
            mb_reg  <= mul_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            ma_reg  <= {ma_reg[MUL_W-2:0], 1'b0};
            mb_reg  <= {mb_reg[MUL_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// File: sv/jvae_serial_div.sv
`timescale 1ns / 1ps

module jvae_serial_div import jvae_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ACC_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output div_status_t         status,
    output logic [VEL_W-1:0]    result
);

    localparam int ITER  = QUO_W / 2;
    localparam int CNT_W = $clog2(ITER);
    localparam int TOP_W = ACC_W - QUO_W;

    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1) << (VEL_W - 1);
    localparam logic [VEL_W-1:0] INT_MAX   = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] INT_MIN   = {1'b1, {(VEL_W-1){1'b0}}};

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] work_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic             sat_reg;
    logic [VEL_W-1:0] res_reg;

    logic [ACC_W-1:0] mag;
    logic [DEN_W:0]   t1;
    logic [DEN_W:0]   t2;
    logic             ge1;
    logic             ge2;
    logic [DEN_W-1:0] r1;
    logic [DEN_W-1:0] r2;
    logic             sat_fin;
    logic [VEL_W-1:0] res_fin;

    // |num| + den/2, rounding half away from zero
    always_comb begin
        mag = (num[ACC_W-1] ? ~num : num)
            + ACC_W'({1'b0, den[DEN_W-1:1]}) + ACC_W'(num[ACC_W-1]);
    end

    // two restoring steps per cycle
    always_comb begin
        t1  = {rem_reg, work_reg[QUO_W-1]};
        ge1 = (t1 >= {1'b0, den_reg});
        r1  = ge1 ? DEN_W'(t1 - {1'b0, den_reg}) : t1[DEN_W-1:0];
        t2  = {r1, work_reg[QUO_W-2]};
        ge2 = (t2 >= {1'b0, den_reg});
        r2  = ge2 ? DEN_W'(t2 - {1'b0, den_reg}) : t2[DEN_W-1:0];
    end

    always_comb begin
        if (neg_reg) begin
            sat_fin = ovf_reg || (work_reg > NEG_LIMIT);
            res_fin = sat_fin ? INT_MIN : VEL_W'(~work_reg[VEL_W-1:0] + VEL_W'(1));
        end else begin
            sat_fin = ovf_reg || (|work_reg[QUO_W-1:VEL_W-1]);
            res_fin = sat_fin ? INT_MAX : work_reg[VEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg  <= den;
            neg_reg  <= num[ACC_W-1];
            rem_reg  <= DEN_W'(mag[ACC_W-1:QUO_W]);
            work_reg <= mag[QUO_W-1:0];
            ovf_reg  <= (DEN_W'(mag[ACC_W-1:ACC_W-TOP_W]) >= den);
        end else if (busy_reg) begin
            rem_reg  <= r2;
            work_reg <= {work_reg[QUO_W-3:0], ge1, ge2};
        end
        if (fin_reg) begin
            res_reg <= res_fin;
            sat_reg <= sat_fin;
        end
    end

    assign status.done      = done_reg;
    assign status.saturated = sat_reg;
    assign result           = res_reg;

endmodule

// File: sv/joint_velocity_accel_estimator_unit.sv
// Per-joint velocity low-pass filter and filtered differentiator. Each request carries a
// joint index, a Q16.16 velocity sample and a 15-bit ms timestamp; the block returns the
// filtered velocity and filtered acceleration (Q16.16), a flag for a zero time step
// (outputs held) and a flag for a result clipped to 32 bits. Joints at or above
// NUM_JOINTS return all zeros and leave state alone. A request with a nonzero time step
// makes two passes through a bit-serial multiply-accumulate and two passes through a
// radix-4 serial divider, in the order MAC, divider, MAC, divider, with a registered
// start handoff before each pass and a final load into the output register. Zero-step
// and out-of-range requests skip the MAC and divider and go straight to the output
// register. One request is processed at a time; a finished result sits in the output
// register while the next request is taken. Time constants are written over the APB
// port at 0x0 (velocity) and 0x4 (acceleration); the user must write them only while
// the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps

module joint_velocity_accel_estimator_unit import jvae_pkg::*; #(
    parameter int NUM_JOINTS = JVAE_NUM_JOINTS
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [JOINT_W-1:0]           s_joint,
    input  logic signed [VEL_W-1:0]      s_velocity_sample,
    input  logic [TICK_W-1:0]            s_tick_ms,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VEL_W-1:0]      m_filtered_velocity_out,
    output logic signed [VEL_W-1:0]      m_acceleration_out,
    output logic                         m_zero_interval,
    output logic                         m_saturated
);

    localparam int DEPTH = (NUM_JOINTS < (1 << JOINT_W)) ? NUM_JOINTS : (1 << JOINT_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC_V = 6'b000010,
        ST_DIV_V = 6'b000100,
        ST_MAC_A = 6'b001000,
        ST_DIV_A = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [TAU_W-1:0]  vel_tau_reg;
    logic [TAU_W-1:0]  acc_tau_reg;
    logic [TICK_W-1:0] last_tick_reg [DEPTH];
    logic [VEL_W-1:0]  fvel_reg [DEPTH];
    logic [VEL_W-1:0]  facc_reg [DEPTH];

    logic              mac_start_reg;
    logic              div_start_reg;
    logic              m_valid_reg;

    logic [IDX_W-1:0]  idx_reg;
    logic [VEL_W-1:0]  sample_reg;
    logic [TICK_W-1:0] dt_reg;
    logic [VEL_W-1:0]  v_old_reg;
    logic [VEL_W-1:0]  a_old_reg;
    logic [OPD_W-1:0]  diff_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [VEL_W-1:0]  res_vel_reg;
    logic [VEL_W-1:0]  res_acc_reg;
    logic              res_zero_reg;
    logic              res_sat_reg;
    logic [VEL_W-1:0]  m_vel_reg;
    logic [VEL_W-1:0]  m_acc_reg;
    logic              m_zero_reg;
    logic              m_sat_reg;

    logic [IDX_W-1:0]  s_idx;
    logic [TICK_W-1:0] cur_tick;
    logic [TICK_W-1:0] dt_in;
    logic              joint_ok;
    logic              in_fire;
    logic              cfg_wr;
    logic              out_load;

    logic              sel_acc;
    logic [OPD_W-1:0]  mac_op_a;
    logic [OPD_W-1:0]  mac_op_b;
    logic [MUL_W-1:0]  mac_mul_a;
    logic [MUL_W-1:0]  mac_mul_b;
    logic              mac_done;
    logic [ACC_W-1:0]  mac_acc;
    div_status_t       div_status;
    logic [VEL_W-1:0]  div_result;

    assign s_idx    = s_joint[IDX_W-1:0];
    assign cur_tick = last_tick_reg[s_idx];
    assign joint_ok = (32'(s_joint) < NUM_JOINTS);
    assign in_fire  = s_valid && s_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // backwards step adds the 32767 ms wrap
    assign dt_in = (s_tick_ms < cur_tick) ? TICK_W'(s_tick_ms - cur_tick + TICK_WRAP_MS)
                                          : TICK_W'(s_tick_ms - cur_tick);

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        unique case (cfg_reg_t'(paddr[2]))
            REG_VELOCITY_TAU: prdata = CFG_DATA_W'(vel_tau_reg);
            REG_ACCEL_TAU:    prdata = CFG_DATA_W'(acc_tau_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (joint_ok && (dt_in != '0)) ? ST_MAC_V : ST_OUT;
                end
            end
            ST_MAC_V: begin
                if (mac_done) state_next = ST_DIV_V;
            end
            ST_DIV_V: begin
                if (div_status.done) state_next = ST_MAC_A;
            end
            ST_MAC_A: begin
                if (mac_done) state_next = ST_DIV_A;
            end
            ST_DIV_A: begin
                if (div_status.done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mac_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            vel_tau_reg   <= TAU_RESET;
            acc_tau_reg   <= TAU_RESET;
            for (int i = 0; i < DEPTH; i++) begin
                last_tick_reg[i] <= '0;
                fvel_reg[i]      <= '0;
                facc_reg[i]      <= '0;
            end
        end else begin
            state_reg     <= state_next;
            mac_start_reg <= (in_fire && joint_ok && (dt_in != '0))
                          || ((state_reg == ST_DIV_V) && div_status.done);
            div_start_reg <= mac_done;
            if (cfg_wr) begin
                unique case (cfg_reg_t'(paddr[2]))
                    REG_VELOCITY_TAU: vel_tau_reg <= pwdata[TAU_W-1:0];
                    REG_ACCEL_TAU:    acc_tau_reg <= pwdata[TAU_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire && joint_ok) begin
                last_tick_reg[s_idx] <= s_tick_ms;
            end
            if ((state_reg == ST_DIV_A) && div_status.done) begin
                fvel_reg[idx_reg] <= res_vel_reg;
                facc_reg[idx_reg] <= div_result;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            idx_reg      <= s_idx;
            sample_reg   <= s_velocity_sample;
            dt_reg       <= dt_in;
            v_old_reg    <= fvel_reg[s_idx];
            a_old_reg    <= facc_reg[s_idx];
            res_vel_reg  <= joint_ok ? fvel_reg[s_idx] : '0;
            res_acc_reg  <= joint_ok ? facc_reg[s_idx] : '0;
            res_zero_reg <= joint_ok && (dt_in == '0);
            res_sat_reg  <= 1'b0;
        end
        if (mac_done) begin
            den_reg <= (sel_acc ? DEN_W'(acc_tau_reg) : DEN_W'(vel_tau_reg)) + DEN_W'(dt_reg);
        end
        if ((state_reg == ST_DIV_V) && div_status.done) begin
            res_vel_reg <= div_result;
            res_sat_reg <= div_status.saturated;
            diff_reg    <= {div_result[VEL_W-1], div_result} - {v_old_reg[VEL_W-1], v_old_reg};
        end
        if ((state_reg == ST_DIV_A) && div_status.done) begin
            res_acc_reg <= div_result;
            res_sat_reg <= res_sat_reg || div_status.saturated;
        end
        if (out_load) begin
            m_vel_reg  <= res_vel_reg;
            m_acc_reg  <= res_acc_reg;
            m_zero_reg <= res_zero_reg;
            m_sat_reg  <= res_sat_reg;
        end
    end

    always_comb begin
        sel_acc   = (state_reg == ST_MAC_A);
        mac_op_a  = sel_acc ? {a_old_reg[VEL_W-1], a_old_reg} : {v_old_reg[VEL_W-1], v_old_reg};
        mac_op_b  = sel_acc ? diff_reg : {sample_reg[VEL_W-1], sample_reg};
        mac_mul_a = sel_acc ? acc_tau_reg : vel_tau_reg;
        mac_mul_b = sel_acc ? MS_PER_S : MUL_W'(dt_reg);
    end

    jvae_serial_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start_reg),
        .op_a    (mac_op_a),
        .op_b    (mac_op_b),
        .mul_a   (mac_mul_a),
        .mul_b   (mac_mul_b),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    jvae_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (mac_acc),
        .den     (den_reg),
        .status  (div_status),
        .result  (div_result)
    );

    assign m_valid                 = m_valid_reg;
    assign m_filtered_velocity_out = m_vel_reg;
    assign m_acceleration_out      = m_acc_reg;
    assign m_zero_interval         = m_zero_reg;
    assign m_saturated             = m_sat_reg;

endmodule

// File: sv/jvae_checker.sv
`timescale 1ns / 1ps

module jvae_checker import jvae_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    pready,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [VEL_W-1:0]        m_filtered_velocity_out,
    input  logic [VEL_W-1:0]        m_acceleration_out,
    input  logic                    m_zero_interval,
    input  logic                    m_saturated
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered_velocity_out)
                                && $stable(m_acceleration_out))
        else $error("stalled result changed");

    a_zero_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_interval |-> !m_saturated)
        else $error("zero interval with saturation");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind joint_velocity_accel_estimator_unit jvae_checker u_jvae_checker (
    .aclk                    (aclk),
    .aresetn                 (aresetn),
    .pready                  (pready),
    .s_valid                 (s_valid),
    .s_ready                 (s_ready),
    .m_valid                 (m_valid),
    .m_ready                 (m_ready),
    .m_filtered_velocity_out (m_filtered_velocity_out),
    .m_acceleration_out      (m_acceleration_out),
    .m_zero_interval         (m_zero_interval),
    .m_saturated             (m_saturated)
);

// File: sim/tb_joint_velocity_accel_estimator_unit.sv
`timescale 1ns / 1ps

module tb_joint_velocity_accel_estimator_unit;
    import jvae_pkg::*;

    localparam int     NJ       = JVAE_NUM_JOINTS;
    localparam longint Q_MAX    = 64'sd2147483647;
    localparam longint Q_MIN    = -64'sd2147483648;
    localparam int     SETTLE   = 80;
    localparam int     N_PHASES = 6;

    typedef struct {
        logic [JOINT_W-1:0]      joint;
        logic signed [VEL_W-1:0] velocity;
        logic [TICK_W-1:0]       tick;
    } vel_req_t;

    typedef struct {
        logic signed [VEL_W-1:0] velocity;
        logic signed [VEL_W-1:0] accel;
        logic                    zero_dt;
        logic                    sat;
    } est_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [JOINT_W-1:0]      s_joint = '0;
    logic signed [VEL_W-1:0] s_velocity_sample = '0;
    logic [TICK_W-1:0]       s_tick_ms = '0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [VEL_W-1:0] m_filtered_velocity_out;
    logic signed [VEL_W-1:0] m_acceleration_out;
    logic                    m_zero_interval;
    logic                    m_saturated;

    joint_velocity_accel_estimator_unit dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_joint                 (s_joint),
        .s_velocity_sample       (s_velocity_sample),
        .s_tick_ms               (s_tick_ms),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_filtered_velocity_out (m_filtered_velocity_out),
        .m_acceleration_out      (m_acceleration_out),
        .m_zero_interval         (m_zero_interval),
        .m_saturated             (m_saturated)
    );

    vel_req_t    pending_reqs[$];
    est_result_t expected_est[$];

    // predictor state
    logic [TAU_W-1:0]  vel_tau = TAU_RESET;
    logic [TAU_W-1:0]  acc_tau = TAU_RESET;
    logic [TICK_W-1:0] est_last_tick[NJ];
    longint            est_vel[NJ];
    longint            est_acc[NJ];

    // generator state
    logic [TICK_W-1:0]       gen_tick[NJ];
    logic signed [VEL_W-1:0] gen_vel[NJ];

    int  n_accepted = 0;
    int  n_results = 0;
    int  n_fail = 0;
    int  n_zero = 0;
    int  n_sat = 0;
    int  n_settings = 1;
    int  src_gap = 0;
    int  sink_gap = 0;
    bit  quiet_tail = 1'b0;
    logic sink_hold = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint round_div_nearest(longint n, longint d);
        if (n < 0)
            return -((-n + d / 2) / d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint clip_q1616(longint v, ref bit sat);
        if (v > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic est_result_t predict_estimate(vel_req_t r);
        est_result_t e;
        longint      v_old;
        longint      a_old;
        longint      v_new;
        longint      a_new;
        longint      dt;
        longint      tv;
        longint      ta;
        bit          sat;
        sat = 1'b0;
        if (r.tick < est_last_tick[r.joint])
            dt = longint'(r.tick) + longint'(TICK_WRAP_MS) - longint'(est_last_tick[r.joint]);
        else
            dt = longint'(r.tick) - longint'(est_last_tick[r.joint]);
        est_last_tick[r.joint] = r.tick;
        v_old = est_vel[r.joint];
        a_old = est_acc[r.joint];
        if (dt == 0) begin
            v_new = v_old;
            a_new = a_old;
        end else begin
            tv = longint'(vel_tau);
            ta = longint'(acc_tau);
            v_new = round_div_nearest(tv * v_old + dt * longint'(r.velocity), tv + dt);
            v_new = clip_q1616(v_new, sat);
            a_new = round_div_nearest(ta * a_old + longint'(MS_PER_S) * (v_new - v_old),
                                      ta + dt);
            a_new = clip_q1616(a_new, sat);
            est_vel[r.joint] = v_new;
            est_acc[r.joint] = a_new;
        end
        e.velocity = v_new[VEL_W-1:0];
        e.accel    = a_new[VEL_W-1:0];
        e.zero_dt  = (dt == 0);
        e.sat      = sat;
        return e;
    endfunction

    function automatic void push_req(int j, logic [31:0] v, int t);
        vel_req_t r;
        r.joint    = JOINT_W'(j);
        r.velocity = v;
        r.tick     = TICK_W'(t);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic vel_req_t make_req();
        vel_req_t    r;
        int unsigned pick;
        r.joint = JOINT_W'($urandom_range(0, NJ - 1));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            gen_tick[r.joint] = gen_tick[r.joint] + TICK_W'($urandom_range(1, 25));
        else if (pick < 78)
            gen_tick[r.joint] = gen_tick[r.joint];
        else if (pick < 90)
            gen_tick[r.joint] = TICK_W'($urandom);
        else
            gen_tick[r.joint] = gen_tick[r.joint] - TICK_W'($urandom_range(1, 100));
        r.tick = gen_tick[r.joint];
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.velocity = gen_vel[r.joint] + VEL_W'(int'($urandom_range(0, 131072)) - 65536);
        else if (pick < 80)
            r.velocity = VEL_W'($urandom);
        else if (pick < 90)
            r.velocity = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        else
            r.velocity = VEL_W'(int'($urandom_range(0, 255)) - 128);
        gen_vel[r.joint] = r.velocity;
        return r;
    endfunction

    task automatic apb_write(input cfg_reg_t idx, input logic [TAU_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CFG_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_VELOCITY_TAU)
            vel_tau = val;
        else
            acc_tau = val;
    endtask

    task automatic drain_and_settle();
        while (pending_reqs.size() != 0 || s_valid || expected_est.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic void log_fail(string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("%t: %s", $realtime, msg);
    endfunction

    // request driver
    always @(posedge aclk) begin : src_drive
        vel_req_t cur;
        vel_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                cur.joint    = s_joint;
                cur.velocity = s_velocity_sample;
                cur.tick     = s_tick_ms;
                expected_est.insert(expected_est.size(), predict_estimate(cur));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(0, 11);
                    s_valid <= 1'b0;
                end else begin
                    nxt = pending_reqs.pop_front();
                    s_valid           <= 1'b1;
                    s_joint           <= nxt.joint;
                    s_velocity_sample <= nxt.velocity;
                    s_tick_ms         <= nxt.tick;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : res_check
        est_result_t e;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (m_zero_interval === 1'b1)
                    n_zero++;
                if (m_saturated === 1'b1)
                    n_sat++;
                if (expected_est.size() == 0) begin
                    log_fail($sformatf("unexpected result vel %0d acc %0d",
                                       m_filtered_velocity_out, m_acceleration_out));
                end else begin
                    e = expected_est.pop_front();
                    if (m_filtered_velocity_out !== e.velocity ||
                        m_acceleration_out !== e.accel ||
                        m_zero_interval !== e.zero_dt || m_saturated !== e.sat)
                        log_fail($sformatf(
                            {"mismatch: exp vel %0d acc %0d zero %0b sat %0b, ",
                             "got vel %0d acc %0d zero %0b sat %0b"},
                            e.velocity, e.accel, e.zero_dt, e.sat,
                            m_filtered_velocity_out, m_acceleration_out,
                            m_zero_interval, m_saturated));
                end
            end
            if (sink_hold) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 11);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    initial begin
        while (n_accepted < 400)
            @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    initial begin : main_seq
        logic [TAU_W-1:0] vt_set[N_PHASES];
        logic [TAU_W-1:0] at_set[N_PHASES];
        int               cnt;
        vt_set = '{16'd0, 16'd65535, 16'd1, 16'd65535, 16'd0, 16'd10};
        at_set = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd3, 16'd10};
        for (int j = 0; j < NJ; j++) begin
            est_last_tick[j] = '0;
            est_vel[j]       = 0;
            est_acc[j]       = 0;
            gen_tick[j]      = '0;
            gen_vel[j]       = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_req(0, 32'h0000_0000, 0);       // same tick as reset
        push_req(0, 32'h7fff_ffff, 1);
        push_req(0, 32'h8000_0000, 2);       // full swing, acceleration clips
        push_req(0, 32'h8000_0000, 2);       // zero interval, hold
        push_req(1, 32'h7fff_ffff, 32767);   // longest forward step
        push_req(1, 32'hffff_ffff, 0);       // wrap lands on zero interval
        push_req(1, 32'h0000_0001, 5);
        push_req(1, 32'h1234_5678, 3);       // timestamp went backwards
        push_req(2, 32'h8000_0000, 32767);
        push_req(2, 32'h7fff_ffff, 32766);
        push_req(3, 32'h7fff_ffff, 1);
        push_req(3, 32'h8000_0000, 2);
        push_req(4, 32'haaaa_aaaa, 15'h5555);
        push_req(4, 32'h5555_5555, 15'h2aaa);
        push_req(5, 32'h5555_5555, 15'h2aaa);
        push_req(5, 32'haaaa_aaaa, 15'h5555);
        push_req(6, 32'hffff_0000, 100);
        push_req(6, 32'h0001_0000, 101);
        push_req(7, 32'h0001_0000, 7);
        push_req(7, 32'h0001_0000, 7);
        push_req(7, 32'hffff_0000, 8);
        for (int j = 0; j < NJ; j++)
            gen_tick[j] = pending_reqs[pending_reqs.size() - 1].tick;
        foreach (pending_reqs[i]) begin
            gen_tick[pending_reqs[i].joint] = pending_reqs[i].tick;
            gen_vel[pending_reqs[i].joint]  = pending_reqs[i].velocity;
        end
        drain_and_settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            apb_write(REG_VELOCITY_TAU, vt_set[ph]);
            apb_write(REG_ACCEL_TAU, at_set[ph]);
            n_settings++;
            @(negedge aclk);
            cnt = 230;
            if (ph == N_PHASES - 1) begin
                quiet_tail = 1'b1;
                cnt = 150;
            end
            repeat (cnt) pending_reqs.insert(pending_reqs.size(), make_req());
            drain_and_settle();
        end

        if (expected_est.size() != 0)
            log_fail($sformatf("%0d results never arrived", expected_est.size()));
        $display("Ran %0d requests over %0d tau settings, %0d results checked",
                 n_accepted, n_settings, n_results);
        $display("Saw %0d zero-interval and %0d saturated results, %0d failures",
                 n_zero, n_sat, n_fail);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/jvae_pkg.sv
sv/jvae_serial_mac.sv
sv/jvae_serial_div.sv
sv/joint_velocity_accel_estimator_unit.sv
sv/jvae_checker.sv
sim/tb_joint_velocity_accel_estimator_unit.sv
